@@ design/assert_macros.svh @@
// Assertion macros for the recorder RTL (included by parameter_lock_recorder_top).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define PLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define PLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/plr_pkg.sv @@
// Package: constants, codes and value tables for the parameter lock recorder.
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

    localparam int PLR_CHANNELS    = 16;
    localparam int PLR_STEPS       = 240;
    localparam int PLR_MAX_RESULTS = 16;

    localparam logic CMD_CTRL = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [6:0] CTL_LATCH      = 7'd60;
    localparam logic [6:0] CTL_CLEAR      = 7'd58;
    localparam logic [6:0] CTL_BANK_A     = 7'd16;
    localparam logic [6:0] CTL_BANK_A_END = 7'd23;
    localparam logic [6:0] CTL_BANK_B     = 7'd120;
    localparam logic [6:0] VAL_FULL       = 7'd127;
    localparam logic [6:0] VAL_ZERO       = 7'd0;

    localparam logic [3:0] CH_BANK_B    = 4'd8;
    localparam logic [3:0] CH_BIPOLAR_A = 4'd0;
    localparam logic [3:0] CH_BIPOLAR_B = 4'd2;

    localparam logic [0:0] CFG_WEIGHT   = 1'b0;
    localparam logic [0:0] CFG_DEADZONE = 1'b1;

    localparam logic [8:0]  WEIGHT_RESET   = 9'd128;
    localparam logic [8:0]  WEIGHT_MAX     = 9'd256;
    localparam logic [14:0] DEADZONE_RESET = 15'd819;

    typedef logic signed [15:0] t_q_tab [128];

    // Q2.14 code for each 7-bit control value, rounded half away from zero.
    function automatic t_q_tab f_build_tab(input bit bipolar);
        t_q_tab tab;
        int     num;
        for (int v = 0; v < 128; v++) begin
            if (bipolar) begin
                num = (v - 63) * 16384;
                if (num >= 0) begin
                    tab[v] = 16'((num + 31) / 63);
                end else begin
                    tab[v] = 16'(-((-num + 31) / 63));
                end
            end else begin
                tab[v] = 16'((v * 16384 + 63) / 127);
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

@@ design/parameter_lock_recorder_top.sv @@
// A control change is written to the store when accepted; latch (60/127) and clear (58/127) sweep all STEPS rows (240).
// Tick: each channel in turn passes through the shared multiplier (S_TMUL, then S_TFIN),
// and S_TFIN holds while the output is stalled; one item in flight at a time.
// Step store holds one row of all channels per step: one row write and one row read per cycle.
// Reset (synchronous, active low) clears control state, then a clearing pass writes zero
// to every step row (STEPS, 240), during which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module parameter_lock_recorder_top #(
    parameter int CHANNELS = plr_pkg::PLR_CHANNELS,
    parameter int STEPS    = plr_pkg::PLR_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [6:0]         i_control_number,
    input  logic [6:0]         i_control_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_channel,
    output logic signed [15:0] o_smoothed_value,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);
    import plr_pkg::*;

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = $clog2(STEPS);
    localparam int NOUT = (CHANNELS < PLR_MAX_RESULTS) ? CHANNELS : PLR_MAX_RESULTS;
    localparam logic [CW-1:0] CH_LASTOUT = CW'(NOUT - 1);
    localparam logic [CW-1:0] CH_END     = CW'(CHANNELS - 1);
    localparam logic [SW-1:0] STEP_END   = SW'(STEPS - 1);
    localparam logic signed [25:0] ROUND_BIAS = 26'sd128;
    localparam t_q_tab TAB_BIP = f_build_tab(1'b1);
    localparam t_q_tab TAB_UNI = f_build_tab(1'b0);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LATCH,
        S_TMUL,
        S_TFIN
    } t_state;

    t_state                r_state;
    logic [SW-1:0]         r_addr;
    logic [SW-1:0]         r_step;
    logic                  r_loop;
    logic [CW-1:0]         r_ch;
    logic [8:0]            r_weight;
    logic [14:0]           r_thr;
    logic signed [15:0]    r_smooth [CHANNELS];
    logic signed [25:0]    r_prod;
    logic                  r_out_valid;
    logic [3:0]            r_out_ch;
    logic signed [15:0]    r_out_val;
    logic                  r_out_last;

    logic signed [15:0]    r_mem [STEPS][CHANNELS];
    logic signed [15:0]    r_rd_row [CHANNELS];

    logic                  w_accept;
    logic                  w_map_hit;
    logic [3:0]            w_map_ch;
    logic                  w_map_ok;
    logic signed [15:0]    w_q;
    logic                  w_we;
    logic [SW-1:0]         w_waddr;
    logic [CHANNELS-1:0]   w_wmask;
    logic signed [15:0]    w_wdata [CHANNELS];
    logic [8:0]            w_w;
    logic signed [15:0]    w_entry;
    logic signed [15:0]    w_prev;
    logic signed [16:0]    w_diff;
    logic signed [25:0]    w_mul;
    logic signed [25:0]    w_sum;
    logic signed [15:0]    w_res;
    logic [16:0]           w_mag;
    logic signed [15:0]    w_s;
    logic                  w_emit;
    logic                  w_out_load;

    assign w_accept         = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_channel        = r_out_ch;
    assign o_smoothed_value = r_out_val;
    assign o_last           = r_out_last;

    // Control to channel mapping
    always_comb begin
        w_map_hit = 1'b0;
        w_map_ch  = '0;
        if (i_control_number >= CTL_BANK_A && i_control_number <= CTL_BANK_A_END) begin
            w_map_hit = 1'b1;
            w_map_ch  = 4'(i_control_number - CTL_BANK_A);
        end else if (i_control_number >= CTL_BANK_B) begin
            w_map_hit = 1'b1;
            w_map_ch  = 4'(i_control_number - CTL_BANK_B) + CH_BANK_B;
        end
    end

    assign w_map_ok = w_map_hit && (int'(w_map_ch) < CHANNELS);
    assign w_q      = (w_map_ch == CH_BIPOLAR_A || w_map_ch == CH_BIPOLAR_B)
                      ? TAB_BIP[i_control_value] : TAB_UNI[i_control_value];

    // Store write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_step;
        w_wmask = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_wdata[c] = r_rd_row[c];
        end
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wmask = '1;
                for (int c = 0; c < CHANNELS; c++) begin
                    w_wdata[c] = '0;
                end
            end
            S_LATCH: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wmask = '1;
            end
            S_IDLE: begin
                if (w_accept && i_command == CMD_CTRL && w_map_ok) begin
                    w_we = 1'b1;
                    for (int c = 0; c < CHANNELS; c++) begin
                        w_wmask[c] = (int'(w_map_ch) == c);
                        w_wdata[c] = w_q;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (w_wmask[c]) begin
                    r_mem[w_waddr][c] <= w_wdata[c];
                end
            end
        end
        r_rd_row <= r_mem[r_step];
    end

    // Shared smoothing unit: s = e + (prev - e) * w / 256, rounded by floor(x + 0.5)
    assign w_w     = (r_weight > WEIGHT_MAX) ? WEIGHT_MAX : r_weight;
    assign w_entry = r_rd_row[r_ch];
    assign w_prev  = r_smooth[r_ch];
    assign w_diff  = {w_prev[15], w_prev} - {w_entry[15], w_entry};
    assign w_mul   = w_diff * $signed({1'b0, w_w});
    assign w_sum   = r_prod + $signed({{2{w_entry[15]}}, w_entry, 8'd0}) + ROUND_BIAS;
    assign w_res   = w_sum[23:8];
    assign w_mag   = w_res[15] ? (17'd0 - {1'b1, w_res}) : {1'b0, w_res};
    assign w_s     = (w_mag < {2'b00, r_thr}) ? '0 : w_res;
    assign w_emit  = (r_ch <= CH_LASTOUT);
    assign w_out_load = (r_state == S_TFIN) && w_emit && !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_step      <= '0;
            r_loop      <= 1'b0;
            r_ch        <= '0;
            r_weight    <= WEIGHT_RESET;
            r_thr       <= DEADZONE_RESET;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_smooth[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WEIGHT:   r_weight <= i_cfg_data[8:0];
                    CFG_DEADZONE: r_thr    <= i_cfg_data;
                endcase
            end
            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR, S_LATCH: begin
                    if (r_addr == STEP_END) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_command == CMD_TICK) begin
                            r_ch    <= '0;
                            r_state <= S_TMUL;
                        end else if (i_control_number == CTL_LATCH &&
                                     i_control_value == VAL_FULL) begin
                            r_addr  <= '0;
                            r_loop  <= 1'b1;
                            r_state <= S_LATCH;
                            for (int c = 0; c < CHANNELS; c++) begin
                                r_smooth[c] <= '0;
                            end
                        end else if (i_control_number == CTL_LATCH &&
                                     i_control_value == VAL_ZERO) begin
                            r_loop <= 1'b0;
                        end else if (i_control_number == CTL_CLEAR &&
                                     i_control_value == VAL_FULL) begin
                            r_addr  <= '0;
                            r_state <= S_CLR;
                        end
                    end
                end
                S_TMUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_TFIN;
                end
                S_TFIN: begin
                    if (!(w_emit && r_out_valid && i_out_stall)) begin
                        r_smooth[r_ch] <= w_s;
                        if (w_emit) begin
                            r_out_valid <= 1'b1;
                            r_out_ch    <= 4'(r_ch);
                            r_out_val   <= w_s;
                            r_out_last  <= (r_ch == CH_LASTOUT);
                        end
                        if (r_ch == CH_END) begin
                            r_state <= S_IDLE;
                            if (r_loop) begin
                                r_step <= (r_step == STEP_END) ? '0 : r_step + 1'b1;
                            end
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_TMUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PLR_ASSERT_SAME(a_last_channel, i_clk, i_rst_n, o_out_valid && o_last,
        o_channel == 4'(NOUT - 1), "last flag on wrong channel")
    `PLR_ASSERT_SAME(a_step_range, i_clk, i_rst_n, 1'b1, r_step <= STEP_END,
        "step index out of range")
    `PLR_ASSERT_NEXT(a_latch_start, i_clk, i_rst_n,
        w_accept && i_command == CMD_CTRL && i_control_number == CTL_LATCH &&
        i_control_value == VAL_FULL,
        r_loop && r_state == S_LATCH, "latch did not start its sweep")
    `PLR_ASSERT_NEXT(a_mul_to_fin, i_clk, i_rst_n, r_state == S_TMUL, r_state == S_TFIN,
        "multiply not followed by finish")

endmodule

`default_nettype wire

@@ tb/sv/parameter_lock_recorder_top_tb.sv @@
// Testbench for the parameter lock recorder: knob capture, latch and loop, clear, tick smoothing.
`timescale 1ns / 1ps

module parameter_lock_recorder_top_tb;
    import plr_pkg::*;

    localparam int N_CH          = PLR_CHANNELS;
    localparam int N_STEP        = PLR_STEPS;
    localparam int N_OUT         = (N_CH < PLR_MAX_RESULTS) ? N_CH : PLR_MAX_RESULTS;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 32;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [15:0] value;
        logic               last;
    } t_channel_result;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic               i_command        = CMD_CTRL;
    logic [6:0]         i_control_number = '0;
    logic [6:0]         i_control_value  = '0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic [3:0]         o_channel;
    logic signed [15:0] o_smoothed_value;
    logic               o_last;
    logic               i_cfg_we         = 1'b0;
    logic [0:0]         i_cfg_index      = CFG_WEIGHT;
    logic [14:0]        i_cfg_data       = '0;

    // predicted state of the recorder
    logic signed [15:0] knob_steps [N_CH][N_STEP];
    logic signed [15:0] smooth_state [N_CH];
    int unsigned        step_pos;
    bit                 looping;
    logic [8:0]         weight_q8;
    logic [14:0]        deadzone_q14;

    t_channel_result    pending_results [$];
    int unsigned        mismatch_count = 0;
    int unsigned        rx_hold        = 0;
    bit                 tx_no_gaps     = 1'b0;
    bit                 rx_no_stalls   = 1'b0;

    parameter_lock_recorder_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_control_number (i_control_number),
        .i_control_value  (i_control_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_channel        (o_channel),
        .o_smoothed_value (o_smoothed_value),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_predictor();
        for (int c = 0; c < N_CH; c++) begin
            smooth_state[c] = '0;
            for (int s = 0; s < N_STEP; s++) begin
                knob_steps[c][s] = '0;
            end
        end
        step_pos     = 0;
        looping      = 1'b0;
        weight_q8    = WEIGHT_RESET;
        deadzone_q14 = DEADZONE_RESET;
    endfunction

    // bipolar channels centre on 63, the rest scale 0..127 onto 0..1.0
    function automatic logic signed [15:0] knob_to_q14(input int ch, input int val);
        int num;
        if (ch == CH_BIPOLAR_A || ch == CH_BIPOLAR_B) begin
            num = (val - 63) * 16384;
            if (num >= 0) begin
                return 16'((num + 31) / 63);
            end
            return 16'(-((31 - num) / 63));
        end
        return 16'((val * 16384 + 63) / 127);
    endfunction

    function automatic void apply_control(input logic [6:0] ctl, input logic [6:0] val);
        int                 ch;
        logic signed [15:0] held;
        ch = -1;
        if (ctl >= CTL_BANK_A && ctl <= CTL_BANK_A_END) begin
            ch = int'(ctl) - int'(CTL_BANK_A);
        end else if (ctl >= CTL_BANK_B) begin
            ch = int'(ctl) - int'(CTL_BANK_B) + int'(CH_BANK_B);
        end
        if (ch >= 0) begin
            if (ch < N_CH) begin
                knob_steps[ch][step_pos] = knob_to_q14(ch, val);
            end
        end else if (ctl == CTL_LATCH) begin
            if (val == VAL_FULL) begin
                for (int c = 0; c < N_CH; c++) begin
                    held = knob_steps[c][step_pos];
                    smooth_state[c] = '0;
                    for (int s = 0; s < N_STEP; s++) begin
                        knob_steps[c][s] = held;
                    end
                end
                looping = 1'b1;
            end else if (val == VAL_ZERO) begin
                looping = 1'b0;
            end
        end else if (ctl == CTL_CLEAR && val == VAL_FULL) begin
            for (int c = 0; c < N_CH; c++) begin
                for (int s = 0; s < N_STEP; s++) begin
                    knob_steps[c][s] = '0;
                end
            end
        end
    endfunction

    function automatic void run_frame_tick();
        int              w;
        int              acc;
        int              r;
        t_channel_result item;
        w = (weight_q8 > WEIGHT_MAX) ? int'(WEIGHT_MAX) : int'(weight_q8);
        for (int c = 0; c < N_CH; c++) begin
            acc = int'(knob_steps[c][step_pos]) * (256 - w) + int'(smooth_state[c]) * w + 128;
            r   = acc >>> 8;
            if ((r < 0 ? -r : r) < int'(deadzone_q14)) begin
                r = 0;
            end
            if (r > 32767) begin
                r = 32767;
            end else if (r < -32768) begin
                r = -32768;
            end
            smooth_state[c] = 16'(r);
            if (c < N_OUT) begin
                item.channel = 4'(c);
                item.value   = 16'(r);
                item.last    = (c == N_OUT - 1);
                pending_results.insert(pending_results.size(), item);
            end
        end
        if (looping) begin
            step_pos = (step_pos + 1) % N_STEP;
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_channel_result want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected ch %0d val %0d last %0b, got ch %0d val %0d last %0b",
                     $time, what, want.channel, want.value, want.last,
                     o_channel, o_smoothed_value, o_last);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_channel_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected transaction", '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_channel !== want.channel || o_smoothed_value !== want.value ||
                        o_last !== want.last) begin
                        note_mismatch("mismatch", want);
                    end
                end
                rx_hold = rx_no_stalls ? 0 : $urandom_range(0, 7);
                i_out_stall <= (rx_hold != 0);
            end else if (rx_hold != 0) begin
                rx_hold--;
                i_out_stall <= (rx_hold != 0);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [6:0] ctl, input logic [6:0] val);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_control_number <= ctl;
        i_control_value  <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (cmd == CMD_TICK) begin
            run_frame_tick();
        end else begin
            apply_control(ctl, val);
        end
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 7'($urandom), 7'($urandom));
    endtask

    task automatic send_knob(input int ch, input int val);
        send_item(CMD_CTRL, (ch < 8) ? 7'(int'(CTL_BANK_A) + ch)
                                     : 7'(int'(CTL_BANK_B) + ch - 8), 7'(val));
    endtask

    // the latch sweep produces no results, so allow it to finish before touching registers
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_registers(input int unsigned weight, input int unsigned deadzone);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WEIGHT;
        i_cfg_data  <= 15'(weight);
        @(posedge i_clk);
        weight_q8    = 9'(weight);
        i_cfg_index <= CFG_DEADZONE;
        i_cfg_data  <= 15'(deadzone);
        @(posedge i_clk);
        deadzone_q14 = 15'(deadzone);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_knob($urandom_range(0, N_CH - 1), $urandom_range(0, 127));
        end else if (pick < 72) begin
            send_tick();
        end else if (pick < 78) begin
            send_item(CMD_CTRL, CTL_LATCH, VAL_FULL);
        end else if (pick < 81) begin
            send_item(CMD_CTRL, CTL_LATCH, VAL_ZERO);
        end else if (pick < 84) begin
            send_item(CMD_CTRL, CTL_CLEAR, VAL_FULL);
        end else begin
            send_item(CMD_CTRL, 7'($urandom), 7'($urandom));
        end
    endtask

    task automatic test_knob_extremes();
        send_item(CMD_CTRL, CTL_BANK_A, VAL_FULL);
        send_item(CMD_CTRL, CTL_BANK_A_END, VAL_ZERO);
        send_item(CMD_CTRL, CTL_BANK_B, VAL_FULL);
        send_item(CMD_CTRL, 7'd127, VAL_FULL);
        send_knob(int'(CH_BIPOLAR_B), 0);
        send_knob(1, 64);
        send_tick();
        send_knob(int'(CH_BIPOLAR_A), 63);
        send_knob(int'(CH_BIPOLAR_B), 127);
        send_tick();
    endtask

    // none of these should touch the store or the loop flag
    task automatic test_unmapped_controls();
        send_item(CMD_CTRL, 7'd0, VAL_FULL);
        send_item(CMD_CTRL, 7'd24, VAL_FULL);
        send_item(CMD_CTRL, 7'd119, VAL_FULL);
        send_item(CMD_CTRL, CTL_LATCH, 7'd1);
        send_item(CMD_CTRL, CTL_CLEAR, VAL_ZERO);
        send_tick();
    endtask

    task automatic test_latch_loop_clear();
        send_knob(5, 100);
        send_item(CMD_CTRL, CTL_LATCH, VAL_FULL);
        send_tick();
        send_knob(5, 10);
        send_tick();
        send_item(CMD_CTRL, CTL_LATCH, VAL_ZERO);
        send_tick();
        send_item(CMD_CTRL, CTL_CLEAR, VAL_FULL);
        send_tick();
    endtask

    task automatic test_register_extremes();
        int unsigned weights [3]   = '{0, 256, 511};
        int unsigned deadzones [3] = '{0, 16384, 32767};
        for (int i = 0; i < 3; i++) begin
            drain_and_settle();
            set_registers(weights[i], deadzones[i]);
            send_knob($urandom_range(0, N_CH - 1), $urandom_range(0, 127));
            send_tick();
            send_tick();
        end
    endtask

    task automatic test_random_sessions();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_and_settle();
            if (p == RANDOM_PHASES - 1) begin
                set_registers(WEIGHT_RESET, DEADZONE_RESET);
            end else begin
                set_registers($urandom_range(0, 511),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                          : $urandom_range(0, 2000));
            end
            tx_no_gaps   = (p == 0);
            rx_no_stalls = (p == 0) || (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
            end
        end
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    initial begin
        reset_predictor();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_knob_extremes();
        test_unmapped_controls();
        test_latch_loop_clear();
        test_register_extremes();
        test_random_sessions();
        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("parameter_lock_recorder_top_tb: clean");
        end else begin
            $display("parameter_lock_recorder_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("parameter_lock_recorder_top_tb: errors");
        $finish;
    end

endmodule
